// File: rtl/core/fvn_pkg.sv
// Shared constants and types for the fractal value noise core.
package fvn_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int FRAC_BITS   = 16;

    localparam int POS_W     = 32 + FRAC_BITS;
    localparam int FRAC_ONE  = 1 << FRAC_BITS;
    localparam int V_W       = FRAC_BITS + 2;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int W_W       = FRAC_BITS + 1;
    localparam int ACC_W     = FRAC_BITS + 6;
    localparam int CNT_W     = $clog2(MAX_OCTAVES + 1);
    localparam int CV_SHIFT  = 30 - FRAC_BITS;
    localparam int OUT_W     = 21;
    localparam int OUT_MAX   = 1048575;
    localparam int OUT_MIN   = -1048576;
    localparam int PERS_W    = 17;
    localparam int PERS_SHIFT = 16;
    localparam int PERS_ONE  = 65536;
    localparam int CELL_LAT  = 12;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED         = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EASED        = 8'd3;

    localparam logic [31:0] HASH_KX   = 32'd1619;
    localparam logic [31:0] HASH_KY   = 32'd31337;
    localparam logic [31:0] HASH_KS   = 32'd1013;
    localparam logic [31:0] HASH_MUL  = 32'd60493;
    localparam logic [31:0] HASH_ADD1 = 32'd19990303;
    localparam logic [31:0] HASH_ADD2 = 32'd1376312589;

    typedef struct packed {
        logic                    valid;
        logic [POS_W-1:0]        x;
        logic [POS_W-1:0]        y;
        logic [31:0]             seed;
        logic [CNT_W-1:0]        rem;
        logic [W_W-1:0]          weight;
        logic signed [ACC_W-1:0] acc;
    } t_bus;

endpackage

// File: rtl/core/fvn_cell.sv
// One octave cell: hashes four corners, blends them and adds the weighted octave.
module fvn_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_eased,
    input  logic [fvn_pkg::PERS_W-1:0]        i_persist,
    input  fvn_pkg::t_bus                     i_bus,
    output fvn_pkg::t_bus                     o_bus
);

    localparam int F    = fvn_pkg::FRAC_BITS;
    localparam int VW   = fvn_pkg::V_W;
    localparam int DW   = fvn_pkg::FRAC_BITS + 3;
    localparam int PW   = 2 * fvn_pkg::FRAC_BITS + 5;
    localparam int WNW  = 2 * fvn_pkg::FRAC_BITS + 4;
    localparam int WPW  = fvn_pkg::W_W + fvn_pkg::PERS_W;
    localparam int EW   = fvn_pkg::FRAC_BITS + 6;
    localparam int LAT  = fvn_pkg::CELL_LAT;

    fvn_pkg::t_bus r_bus [0:LAT-1];
    fvn_pkg::t_bus n_last;

    logic [31:0]  r_ha, r_hb, r_hc;
    logic [30:0]  r_n1 [0:3];
    logic [30:0]  r_n1d [0:3];
    logic [30:0]  r_n1dd [0:3];
    logic [31:0]  r_sq [0:3];
    logic [31:0]  r_m [0:3];
    logic [31:0]  r_h [0:3];
    logic signed [VW-1:0] r_cv [0:3];
    logic [30:0]  n_n0 [0:3];
    logic [30:0]  n_n1 [0:3];
    logic [31:0]  n_hsum [0:3];
    logic [31:0]  w_off [0:3];

    logic [F-1:0] r_t2x, r_t2y, r_t3x, r_t3y, r_t4x, r_t4y, r_t5x, r_t5y;
    logic [F-1:0] r_t3dx, r_t3dy, r_t3ddx, r_t3ddy, r_t4dx, r_t4dy;
    logic [2*F-1:0] n_p2x, n_p2y, n_p3x, n_p3y, n_p4x, n_p4y, n_p5x, n_p5y;
    logic signed [EW-1:0] n_ex, n_ey;
    logic [fvn_pkg::T_W-1:0] n_fx, n_fy;
    logic [fvn_pkg::T_W-1:0] r_fx, r_fy, r_fx2, r_fy2, r_fy3, r_fy4;

    logic signed [DW-1:0] n_d0, n_d1, n_dd;
    logic signed [PW-1:0] r_p0, r_p1, r_pd, n_p0, n_p1, n_pd;
    logic signed [VW-1:0] r_a0, r_a1, r_u, r_v, r_u2, r_n;
    logic signed [PW-1:0] n_usum, n_vsum, n_nsum;
    logic signed [WNW-1:0] r_wn, n_wn;
    logic [WPW-1:0]        r_wp, n_wp;
    logic                  w_active;

    // Offsets of the corners (x, y), (x+1, y), (x, y+1), (x+1, y+1) in the linear hash sum.
    assign w_off[0] = 32'd0;
    assign w_off[1] = fvn_pkg::HASH_KX;
    assign w_off[2] = fvn_pkg::HASH_KY;
    assign w_off[3] = fvn_pkg::HASH_KX + fvn_pkg::HASH_KY;

    always_comb begin
        n_p2x = i_bus.x[F-1:0] * i_bus.x[F-1:0];
        n_p2y = i_bus.y[F-1:0] * i_bus.y[F-1:0];
        n_p3x = r_t2x * r_bus[0].x[F-1:0];
        n_p3y = r_t2y * r_bus[0].y[F-1:0];
        n_p4x = r_t3x * r_bus[1].x[F-1:0];
        n_p4y = r_t3y * r_bus[1].y[F-1:0];
        n_p5x = r_t4x * r_bus[2].x[F-1:0];
        n_p5y = r_t4y * r_bus[2].y[F-1:0];
        n_ex = EW'(6) * $signed({6'd0, r_t5x}) - EW'(15) * $signed({6'd0, r_t4dx})
             + EW'(10) * $signed({6'd0, r_t3ddx});
        n_ey = EW'(6) * $signed({6'd0, r_t5y}) - EW'(15) * $signed({6'd0, r_t4dy})
             + EW'(10) * $signed({6'd0, r_t3ddy});
        if (!i_eased) begin
            n_fx = {1'b0, r_bus[3].x[F-1:0]};
            n_fy = {1'b0, r_bus[3].y[F-1:0]};
        end else begin
            if (n_ex < 0) begin
                n_fx = '0;
            end else if (n_ex > EW'(fvn_pkg::FRAC_ONE)) begin
                n_fx = fvn_pkg::T_W'(fvn_pkg::FRAC_ONE);
            end else begin
                n_fx = n_ex[fvn_pkg::T_W-1:0];
            end
            if (n_ey < 0) begin
                n_fy = '0;
            end else if (n_ey > EW'(fvn_pkg::FRAC_ONE)) begin
                n_fy = fvn_pkg::T_W'(fvn_pkg::FRAC_ONE);
            end else begin
                n_fy = n_ey[fvn_pkg::T_W-1:0];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_n0[k]   = 31'(r_ha + r_hb + r_hc + w_off[k]);
            n_n1[k]   = {13'd0, n_n0[k][30:13]} ^ n_n0[k];
            n_hsum[k] = r_h[k] + fvn_pkg::HASH_ADD2;
        end
    end

    always_comb begin
        n_d0   = DW'(r_cv[1]) - DW'(r_cv[0]);
        n_d1   = DW'(r_cv[3]) - DW'(r_cv[2]);
        n_p0   = n_d0 * $signed({1'b0, r_fx2});
        n_p1   = n_d1 * $signed({1'b0, r_fx2});
        n_usum = PW'(r_a0) + (r_p0 >>> F);
        n_vsum = PW'(r_a1) + (r_p1 >>> F);
        n_dd   = DW'(r_v) - DW'(r_u);
        n_pd   = n_dd * $signed({1'b0, r_fy4});
        n_nsum = PW'(r_u2) + (r_pd >>> F);
        n_wn   = $signed({1'b0, r_bus[9].weight}) * r_n;
        n_wp   = r_bus[9].weight * i_persist;
    end

    always_comb begin
        n_last = r_bus[10];
        w_active = (r_bus[10].rem != '0);
        n_last.x    = {r_bus[10].x[fvn_pkg::POS_W-2:0], 1'b0};
        n_last.y    = {r_bus[10].y[fvn_pkg::POS_W-2:0], 1'b0};
        n_last.seed = r_bus[10].seed + 32'd1;
        n_last.weight = r_wp[fvn_pkg::PERS_SHIFT +: fvn_pkg::W_W];
        if (w_active) begin
            n_last.rem = r_bus[10].rem - 1'b1;
            n_last.acc = r_bus[10].acc + fvn_pkg::ACC_W'(r_wn >>> F);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_bus[k].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_bus[0] <= i_bus;
            for (int k = 1; k < LAT - 1; k++) begin
                r_bus[k] <= r_bus[k-1];
            end
            r_bus[LAT-1] <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Lattice corner is the integer part, wrapped to 32 bits.
            r_ha  <= i_bus.x[F +: 32] * fvn_pkg::HASH_KX;
            r_hb  <= i_bus.y[F +: 32] * fvn_pkg::HASH_KY;
            r_hc  <= i_bus.seed * fvn_pkg::HASH_KS;
            r_t2x <= n_p2x[2*F-1:F];
            r_t2y <= n_p2y[2*F-1:F];
            r_t3x <= n_p3x[2*F-1:F];
            r_t3y <= n_p3y[2*F-1:F];
            r_t4x <= n_p4x[2*F-1:F];
            r_t4y <= n_p4y[2*F-1:F];
            r_t3dx <= r_t3x;
            r_t3dy <= r_t3y;
            r_t5x <= n_p5x[2*F-1:F];
            r_t5y <= n_p5y[2*F-1:F];
            r_t4dx <= r_t4x;
            r_t4dy <= r_t4y;
            r_t3ddx <= r_t3dx;
            r_t3ddy <= r_t3dy;
            r_fx  <= n_fx;
            r_fy  <= n_fy;
            for (int k = 0; k < 4; k++) begin
                r_n1[k]   <= n_n1[k];
                r_sq[k]   <= {1'b0, r_n1[k]} * {1'b0, r_n1[k]};
                r_n1d[k]  <= r_n1[k];
                r_m[k]    <= r_sq[k] * fvn_pkg::HASH_MUL + fvn_pkg::HASH_ADD1;
                r_n1dd[k] <= r_n1d[k];
                r_h[k]    <= {1'b0, r_n1dd[k]} * r_m[k];
                r_cv[k]   <= VW'(fvn_pkg::FRAC_ONE)
                           - VW'({1'b0, n_hsum[k][30:fvn_pkg::CV_SHIFT]});
            end
            r_fx2 <= r_fx;
            r_fy2 <= r_fy;
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_a0  <= r_cv[0];
            r_a1  <= r_cv[2];
            r_fy3 <= r_fy2;
            r_u   <= n_usum[VW-1:0];
            r_v   <= n_vsum[VW-1:0];
            r_fy4 <= r_fy3;
            r_pd  <= n_pd;
            r_u2  <= r_u;
            r_n   <= n_nsum[VW-1:0];
            r_wn  <= n_wn;
            r_wp  <= n_wp;
        end
    end

    assign o_bus = r_bus[LAT-1];

endmodule

// File: rtl/core/fractal_value_noise_2d_core.sv
// Fractal 2D value noise: one pipelined cell per octave, chained, with a skid output.
// Each octave cell is a fully pipelined 12-stage unit; a finished beat is registered at the output.
// Throughput: one beat per cycle while o_ready is high.
// The input is held off only while the skid register holds a beat the sink has not taken.
// Reset (synchronous, active low) empties the pipeline and sets octave_count 1,
// persistence 0.5, seed 0 and eased 1.
module fractal_value_noise_2d_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [31:0]                 i_x_pos,
    input  logic signed [31:0]                 i_y_pos,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [fvn_pkg::OUT_W-1:0]   o_noise_value,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fvn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fvn_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [3:0]                  r_octave_count;
    logic [fvn_pkg::PERS_W-1:0]  r_persistence;
    logic [31:0]                 r_seed;
    logic                        r_eased;

    logic [fvn_pkg::CNT_W-1:0]   w_count;
    logic [fvn_pkg::PERS_W-1:0]  w_persist;
    logic                        w_en;
    logic                        w_last_fire;
    logic signed [31:0]          w_acc_ext;
    logic signed [fvn_pkg::OUT_W-1:0] w_sat;

    fvn_pkg::t_bus w_chain [0:fvn_pkg::MAX_OCTAVES];

    logic                              r_out_valid, r_skid_valid;
    logic signed [fvn_pkg::OUT_W-1:0]  r_out, r_skid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= 4'd1;
            r_persistence  <= fvn_pkg::PERS_W'(32768);
            r_seed         <= 32'd0;
            r_eased        <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fvn_pkg::REG_OCTAVE_COUNT: r_octave_count <= i_cfg_data[3:0];
                fvn_pkg::REG_PERSISTENCE:  r_persistence  <= i_cfg_data[fvn_pkg::PERS_W-1:0];
                fvn_pkg::REG_SEED:         r_seed         <= i_cfg_data;
                fvn_pkg::REG_EASED:        r_eased        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (int'(r_octave_count) > fvn_pkg::MAX_OCTAVES) begin
            w_count = fvn_pkg::CNT_W'(fvn_pkg::MAX_OCTAVES);
        end else begin
            w_count = fvn_pkg::CNT_W'(r_octave_count);
        end
        if (r_persistence > fvn_pkg::PERS_W'(fvn_pkg::PERS_ONE)) begin
            w_persist = fvn_pkg::PERS_W'(fvn_pkg::PERS_ONE);
        end else begin
            w_persist = r_persistence;
        end
    end

    assign w_en    = !r_skid_valid;
    assign o_ready = w_en;

    always_comb begin
        w_chain[0].valid  = i_valid & w_en;
        w_chain[0].x      = fvn_pkg::POS_W'(i_x_pos);
        w_chain[0].y      = fvn_pkg::POS_W'(i_y_pos);
        w_chain[0].seed   = r_seed;
        w_chain[0].rem    = w_count;
        w_chain[0].weight = fvn_pkg::W_W'(fvn_pkg::FRAC_ONE);
        w_chain[0].acc    = '0;
    end

    for (genvar g = 0; g < fvn_pkg::MAX_OCTAVES; g++) begin : g_cell
        fvn_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_eased   (r_eased),
            .i_persist (w_persist),
            .i_bus     (w_chain[g]),
            .o_bus     (w_chain[g+1])
        );
    end

    always_comb begin
        w_acc_ext = 32'(w_chain[fvn_pkg::MAX_OCTAVES].acc);
        if (w_acc_ext > fvn_pkg::OUT_MAX) begin
            w_sat = fvn_pkg::OUT_W'(fvn_pkg::OUT_MAX);
        end else if (w_acc_ext < fvn_pkg::OUT_MIN) begin
            w_sat = fvn_pkg::OUT_W'(fvn_pkg::OUT_MIN);
        end else begin
            w_sat = w_acc_ext[fvn_pkg::OUT_W-1:0];
        end
    end

    assign w_last_fire = w_en & w_chain[fvn_pkg::MAX_OCTAVES].valid;

    // A beat leaving the pipeline while the output register is blocked parks in the skid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (w_last_fire) begin
                r_out       <= w_sat;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (w_last_fire) begin
            r_skid       <= w_sat;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_noise_value = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && w_last_fire) |=> r_skid_valid)
        else $error("beat leaving the pipeline was not parked in the skid register");

    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready))
        else $error("skid register filled while the output register was free");

endmodule
